>>> src/clp_pkg.sv
// shared types and codes for the cursor linked-list pool
`default_nettype none

package clp_pkg;

    // field widths fixed by the item format
    localparam int MODE_W   = 3;
    localparam int POS_W    = 8;
    localparam int CUR_W    = 9;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_NEW    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FIND   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CAT    = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    // null cursor as seen on the result ports
    localparam logic [CUR_W-1:0] CUR_NULL = 9'h1FF;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_TAKE,
        S_POP,
        S_GOT_NULL,
        S_INS_RD,
        S_INS_LINK,
        S_INS_HEAD,
        S_DEL_CHK,
        S_DEL_UNLINK,
        S_WALK,
        S_CAT_LINK,
        S_FREE_RD,
        S_FREE_WR,
        S_FREE_HEAD,
        S_READ_OUT,
        S_NOP
    } state_t;

endpackage

`default_nettype wire

>>> src/cursor_linked_list_pool.sv
// Cursor linked-list pool: a fixed pool of linked entries with a LIFO free list headed by
// entry 0. After reset the block runs a clearing pass that chains every entry to the next,
// with busy high. An item is taken when start is high and busy is low; its single result
// appears on the result ports for exactly one cycle with done high, in the cycle busy
// drops, and cannot be held off. How long an item stays busy is set by the single link
// memory with one read and one write port; find_end and concatenate follow one link per
// step, and an item ends early when the pool is full, when there is nothing to delete or
// for an unused mode.
`default_nettype none

module cursor_linked_list_pool #(
    parameter int POOL_ENTRIES = 256,
    parameter int VALUE_BITS   = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [clp_pkg::MODE_W-1:0]        mode,
    input  wire logic [clp_pkg::POS_W-1:0]         position,
    input  wire logic [clp_pkg::POS_W-1:0]         second_head,
    input  wire logic signed [clp_pkg::VAL_W-1:0]  value_in,
    output logic                                   busy,
    output logic                                   done,
    output logic [clp_pkg::STATUS_W-1:0]           status,
    output logic signed [clp_pkg::CUR_W-1:0]       cursor_out,
    output logic signed [clp_pkg::CUR_W-1:0]       next_out,
    output logic signed [clp_pkg::VAL_W-1:0]       value_out
);

    localparam int IW = $clog2(POOL_ENTRIES);
    localparam int LW = IW + 1;

    logic                  lk_we;
    logic [IW-1:0]         lk_waddr;
    logic [LW-1:0]         lk_wdata;
    logic [IW-1:0]         lk_raddr;
    logic [LW-1:0]         lk_rdata;
    logic                  val_we;
    logic [IW-1:0]         val_waddr;
    logic [VALUE_BITS-1:0] val_wdata;
    logic [IW-1:0]         val_raddr;
    logic [VALUE_BITS-1:0] val_rdata;

    clp_ram #(
        .DEPTH (POOL_ENTRIES),
        .WIDTH (LW)
    ) u_link_mem (
        .clk   (clk),
        .we    (lk_we),
        .waddr (lk_waddr),
        .wdata (lk_wdata),
        .raddr (lk_raddr),
        .rdata (lk_rdata)
    );

    clp_ram #(
        .DEPTH (POOL_ENTRIES),
        .WIDTH (VALUE_BITS)
    ) u_value_mem (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    clp_seq #(
        .POOL_ENTRIES (POOL_ENTRIES),
        .VALUE_BITS   (VALUE_BITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .mode        (mode),
        .position    (position),
        .second_head (second_head),
        .value_in    (value_in),
        .busy        (busy),
        .done        (done),
        .status      (status),
        .cursor_out  (cursor_out),
        .next_out    (next_out),
        .value_out   (value_out),
        .lk_we       (lk_we),
        .lk_waddr    (lk_waddr),
        .lk_wdata    (lk_wdata),
        .lk_raddr    (lk_raddr),
        .lk_rdata    (lk_rdata),
        .val_we      (val_we),
        .val_waddr   (val_waddr),
        .val_wdata   (val_wdata),
        .val_raddr   (val_raddr),
        .val_rdata   (val_rdata)
    );

endmodule

`default_nettype wire

>>> src/clp_ram.sv
// simple dual-port ram, one write and one registered read per cycle
`default_nettype none

module clp_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> src/clp_seq.sv
// sequencer and datapath that runs each operation over the link and value memories
`default_nettype none

module clp_seq #(
    parameter int POOL_ENTRIES = 256,
    parameter int VALUE_BITS   = 32,
    localparam int IW = $clog2(POOL_ENTRIES),
    localparam int LW = IW + 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [clp_pkg::MODE_W-1:0]    mode,
    input  wire logic [clp_pkg::POS_W-1:0]     position,
    input  wire logic [clp_pkg::POS_W-1:0]     second_head,
    input  wire logic signed [clp_pkg::VAL_W-1:0] value_in,
    output logic                               busy,
    output logic                               done,
    output logic [clp_pkg::STATUS_W-1:0]       status,
    output logic signed [clp_pkg::CUR_W-1:0]   cursor_out,
    output logic signed [clp_pkg::CUR_W-1:0]   next_out,
    output logic signed [clp_pkg::VAL_W-1:0]   value_out,
    // link memory
    output logic                               lk_we,
    output logic [IW-1:0]                      lk_waddr,
    output logic [LW-1:0]                      lk_wdata,
    output logic [IW-1:0]                      lk_raddr,
    input  wire logic [LW-1:0]                 lk_rdata,
    // value memory
    output logic                               val_we,
    output logic [IW-1:0]                      val_waddr,
    output logic [VALUE_BITS-1:0]              val_wdata,
    output logic [IW-1:0]                      val_raddr,
    input  wire logic [VALUE_BITS-1:0]         val_rdata
);

    localparam int SW = $clog2(POOL_ENTRIES + 1);
    localparam logic [IW-1:0] FREE_HEAD = '0;
    localparam logic [IW-1:0] LAST_ENTRY = IW'(POOL_ENTRIES - 1);
    localparam logic [SW-1:0] STEP_LIMIT = SW'(POOL_ENTRIES);
    // links carry a null flag above the entry index
    localparam logic [LW-1:0] NULL_LINK = {1'b1, {IW{1'b0}}};

    function automatic logic [clp_pkg::CUR_W-1:0] field9(input logic [LW-1:0] lk);
        logic [IW+clp_pkg::CUR_W-1:0] wide;
        begin
            wide = {{clp_pkg::CUR_W{1'b0}}, lk[IW-1:0]};
            if (lk[LW-1])
            begin
                field9 = clp_pkg::CUR_NULL;
            end
            else
            begin
                field9 = wide[clp_pkg::CUR_W-1:0];
            end
        end
    endfunction

    // index reduction modulo the pool size, worked out at elaboration
    logic [IW-1:0] pos_mod_tab [256];
    for (genvar g = 0; g < 256; g++)
    begin : g_mod_tab
        assign pos_mod_tab[g] = IW'(g % POOL_ENTRIES);
    end

    logic [IW-1:0] pos_mod;
    logic [IW-1:0] bhead_mod;
    logic [63:0]   vin_wide;
    logic [63:0]   vout_wide;
    assign pos_mod   = pos_mod_tab[position];
    assign bhead_mod = pos_mod_tab[second_head];
    assign vin_wide  = 64'(value_in);
    assign vout_wide = 64'($signed(val_rdata));

    clp_pkg::state_t state_reg, state_next;
    logic [clp_pkg::MODE_W-1:0]   mode_reg, mode_next;
    logic [IW-1:0]                pos_reg, pos_next;
    logic [IW-1:0]                bhead_reg, bhead_next;
    logic [VALUE_BITS-1:0]        val_reg, val_next;
    logic [IW-1:0]                node_reg, node_next;
    logic [IW-1:0]                at_reg, at_next;
    logic [SW-1:0]                steps_reg, steps_next;
    logic [IW-1:0]                clr_reg, clr_next;
    logic                         done_reg, done_next;
    logic [clp_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [clp_pkg::CUR_W-1:0]    cursor_reg, cursor_next;
    logic [clp_pkg::CUR_W-1:0]    next_reg, next_next;
    logic [clp_pkg::VAL_W-1:0]    value_reg, value_next;

    logic lk_null;
    logic walk_stop;
    logic is_alloc;
    assign lk_null   = lk_rdata[LW-1];
    assign walk_stop = lk_null || (steps_reg == STEP_LIMIT);
    assign is_alloc  = (mode == clp_pkg::MODE_NEW) || (mode == clp_pkg::MODE_INSERT);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            clp_pkg::S_CLEAR:
            begin
                if (clr_reg == LAST_ENTRY)
                begin
                    state_next = clp_pkg::S_IDLE;
                end
            end
            clp_pkg::S_IDLE:
            begin
                if (start)
                begin
                    unique case (mode)
                        clp_pkg::MODE_NEW:    state_next = clp_pkg::S_TAKE;
                        clp_pkg::MODE_INSERT: state_next = clp_pkg::S_TAKE;
                        clp_pkg::MODE_DELETE: state_next = clp_pkg::S_DEL_CHK;
                        clp_pkg::MODE_FIND:   state_next = clp_pkg::S_WALK;
                        clp_pkg::MODE_READ:   state_next = clp_pkg::S_READ_OUT;
                        clp_pkg::MODE_CAT:    state_next = clp_pkg::S_WALK;
                        default:              state_next = clp_pkg::S_NOP;
                    endcase
                end
            end
            clp_pkg::S_TAKE:
            begin
                state_next = lk_null ? clp_pkg::S_IDLE : clp_pkg::S_POP;
            end
            clp_pkg::S_POP:
            begin
                state_next = clp_pkg::S_GOT_NULL;
            end
            clp_pkg::S_GOT_NULL:
            begin
                state_next = (mode_reg == clp_pkg::MODE_NEW) ? clp_pkg::S_IDLE
                                                             : clp_pkg::S_INS_RD;
            end
            clp_pkg::S_INS_RD:
            begin
                state_next = clp_pkg::S_INS_LINK;
            end
            clp_pkg::S_INS_LINK:
            begin
                state_next = clp_pkg::S_INS_HEAD;
            end
            clp_pkg::S_DEL_CHK:
            begin
                state_next = lk_null ? clp_pkg::S_IDLE : clp_pkg::S_DEL_UNLINK;
            end
            clp_pkg::S_DEL_UNLINK:
            begin
                state_next = clp_pkg::S_FREE_RD;
            end
            clp_pkg::S_WALK:
            begin
                if (walk_stop)
                begin
                    state_next = (mode_reg == clp_pkg::MODE_CAT) ? clp_pkg::S_CAT_LINK
                                                                 : clp_pkg::S_IDLE;
                end
            end
            clp_pkg::S_CAT_LINK:
            begin
                state_next = clp_pkg::S_FREE_RD;
            end
            clp_pkg::S_FREE_RD:
            begin
                state_next = clp_pkg::S_FREE_WR;
            end
            clp_pkg::S_FREE_WR:
            begin
                state_next = clp_pkg::S_FREE_HEAD;
            end
            clp_pkg::S_INS_HEAD,
            clp_pkg::S_FREE_HEAD,
            clp_pkg::S_READ_OUT,
            clp_pkg::S_NOP:
            begin
                state_next = clp_pkg::S_IDLE;
            end
            default:
            begin
                state_next = clp_pkg::S_IDLE;
            end
        endcase
    end

    // memory controls, datapath and results
    always_comb
    begin
        lk_we       = 1'b0;
        lk_waddr    = node_reg;
        lk_wdata    = NULL_LINK;
        lk_raddr    = pos_reg;
        val_we      = 1'b0;
        val_waddr   = node_reg;
        val_wdata   = val_reg;
        val_raddr   = pos_reg;
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        bhead_next  = bhead_reg;
        val_next    = val_reg;
        node_next   = node_reg;
        at_next     = at_reg;
        steps_next  = steps_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        cursor_next = cursor_reg;
        next_next   = next_reg;
        value_next  = value_reg;

        unique case (state_reg)
            clp_pkg::S_CLEAR:
            begin
                lk_we    = 1'b1;
                lk_waddr = clr_reg;
                lk_wdata = (clr_reg == LAST_ENTRY) ? NULL_LINK
                                                   : {1'b0, IW'(clr_reg + 1'b1)};
                clr_next = IW'(clr_reg + 1'b1);
            end
            clp_pkg::S_IDLE:
            begin
                // issue the first read together with the accept
                lk_raddr  = is_alloc ? FREE_HEAD : pos_mod;
                val_raddr = pos_mod;
                if (start)
                begin
                    mode_next  = mode;
                    pos_next   = pos_mod;
                    bhead_next = bhead_mod;
                    val_next   = vin_wide[VALUE_BITS-1:0];
                    at_next    = pos_mod;
                    steps_next = '0;
                end
            end
            clp_pkg::S_TAKE:
            begin
                if (lk_null)
                begin
                    done_next   = 1'b1;
                    status_next = clp_pkg::STAT_FULL;
                    cursor_next = clp_pkg::CUR_NULL;
                    next_next   = '0;
                    value_next  = '0;
                end
                else
                begin
                    node_next = lk_rdata[IW-1:0];
                    lk_raddr  = lk_rdata[IW-1:0];
                end
            end
            clp_pkg::S_POP:
            begin
                lk_we    = 1'b1;
                lk_waddr = FREE_HEAD;
                lk_wdata = lk_rdata;
            end
            clp_pkg::S_GOT_NULL:
            begin
                lk_we    = 1'b1;
                lk_waddr = node_reg;
                lk_wdata = NULL_LINK;
                if (mode_reg == clp_pkg::MODE_NEW)
                begin
                    done_next   = 1'b1;
                    status_next = clp_pkg::STAT_DONE;
                    cursor_next = field9({1'b0, node_reg});
                    next_next   = '0;
                    value_next  = '0;
                end
                else
                begin
                    val_we = 1'b1;
                end
            end
            clp_pkg::S_INS_RD:
            begin
                lk_raddr = pos_reg;
            end
            clp_pkg::S_INS_LINK:
            begin
                lk_we    = 1'b1;
                lk_waddr = node_reg;
                lk_wdata = lk_rdata;
            end
            clp_pkg::S_INS_HEAD:
            begin
                lk_we       = 1'b1;
                lk_waddr    = pos_reg;
                lk_wdata    = {1'b0, node_reg};
                done_next   = 1'b1;
                status_next = clp_pkg::STAT_DONE;
                cursor_next = field9({1'b0, node_reg});
                next_next   = '0;
                value_next  = '0;
            end
            clp_pkg::S_DEL_CHK:
            begin
                if (lk_null)
                begin
                    done_next   = 1'b1;
                    status_next = clp_pkg::STAT_EMPTY;
                    cursor_next = clp_pkg::CUR_NULL;
                    next_next   = '0;
                    value_next  = '0;
                end
                else
                begin
                    node_next = lk_rdata[IW-1:0];
                    lk_raddr  = lk_rdata[IW-1:0];
                end
            end
            clp_pkg::S_DEL_UNLINK:
            begin
                lk_we    = 1'b1;
                lk_waddr = pos_reg;
                lk_wdata = lk_rdata;
            end
            clp_pkg::S_WALK:
            begin
                if (walk_stop)
                begin
                    if (mode_reg == clp_pkg::MODE_CAT)
                    begin
                        node_next = bhead_reg;
                        lk_raddr  = bhead_reg;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = clp_pkg::STAT_DONE;
                        cursor_next = field9({1'b0, at_reg});
                        next_next   = '0;
                        value_next  = '0;
                    end
                end
                else
                begin
                    at_next    = lk_rdata[IW-1:0];
                    lk_raddr   = lk_rdata[IW-1:0];
                    steps_next = SW'(steps_reg + 1'b1);
                end
            end
            clp_pkg::S_CAT_LINK:
            begin
                lk_we    = 1'b1;
                lk_waddr = at_reg;
                lk_wdata = lk_rdata;
            end
            clp_pkg::S_FREE_RD:
            begin
                lk_raddr = FREE_HEAD;
            end
            clp_pkg::S_FREE_WR:
            begin
                lk_we    = 1'b1;
                lk_waddr = node_reg;
                lk_wdata = lk_rdata;
            end
            clp_pkg::S_FREE_HEAD:
            begin
                lk_we       = 1'b1;
                lk_waddr    = FREE_HEAD;
                lk_wdata    = {1'b0, node_reg};
                done_next   = 1'b1;
                status_next = clp_pkg::STAT_DONE;
                cursor_next = (mode_reg == clp_pkg::MODE_CAT) ? field9({1'b0, pos_reg})
                                                              : clp_pkg::CUR_NULL;
                next_next   = '0;
                value_next  = '0;
            end
            clp_pkg::S_READ_OUT:
            begin
                done_next   = 1'b1;
                status_next = clp_pkg::STAT_DONE;
                cursor_next = field9({1'b0, pos_reg});
                next_next   = field9(lk_rdata);
                value_next  = vout_wide[clp_pkg::VAL_W-1:0];
            end
            clp_pkg::S_NOP:
            begin
                done_next   = 1'b1;
                status_next = clp_pkg::STAT_DONE;
                cursor_next = clp_pkg::CUR_NULL;
                next_next   = '0;
                value_next  = '0;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= clp_pkg::S_CLEAR;
            clr_reg   <= '0;
            steps_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            steps_reg <= steps_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        pos_reg    <= pos_next;
        bhead_reg  <= bhead_next;
        val_reg    <= val_next;
        node_reg   <= node_next;
        at_reg     <= at_next;
        status_reg <= status_next;
        cursor_reg <= cursor_next;
        next_reg   <= next_next;
        value_reg  <= value_next;
    end

    assign busy       = (state_reg != clp_pkg::S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign cursor_out = cursor_reg;
    assign next_out   = next_reg;
    assign value_out  = value_reg;

`ifndef SYNTHESIS
    // every accepted item makes the block busy in the cycle after it is taken
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    // one result per item, never two strobes in a row
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // a full pool never reports an allocated entry
    a_full_null: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == clp_pkg::STAT_FULL)) |-> (cursor_out == clp_pkg::CUR_NULL))
        else $error("pool full result carries an entry");

    // the walk step count is bounded by the pool size
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        steps_reg <= STEP_LIMIT)
        else $error("walk ran past the pool size");

    // a result only follows a busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> $past(busy))
        else $error("result without a preceding operation");
`endif

endmodule

`default_nettype wire
